/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ASSERT_PROP(lbl, clk, rst_n, (!(expr)))

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* sv/sbbs_pkg.sv */
`timescale 1ns / 1ps

package sbbs_pkg;

    // Fixed field widths of the item and result ports.
    localparam int KIND_W     = 2;
    localparam int STEP_IN_W  = 4;
    localparam int TIME_IN_W  = 16;
    localparam int WORD_W     = 16;
    localparam int CFG_W      = 16;

    // Defaults for the top level parameters.
    localparam int SBBS_STEP_COUNT = 16;
    localparam int SBBS_TIME_BITS  = 16;

    // Queue depths between the parts of the block.
    localparam int IQ_DEPTH = 4;
    localparam int RQ_DEPTH = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;

    // Item kind codes.
    localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLINK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;

    // Operations handed from the front to the back.
    typedef enum logic [1:0] {
        OP_SCAN,
        OP_BLINK,
        OP_LOAD,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic              led_on;
        logic [WORD_W-1:0] pattern;
        logic              toggled;
    } t_result;

endpackage

/* sv/sbbs_fifo.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbbs_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_fire, pop_fire;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign push_fire = i_push && !o_full;
    assign pop_fire  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_fire) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push_fire, pop_fire})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, (r_count > CNT_FULL))
    `ASSERT_PROP(a_count_up, i_clk, i_rst_n, ((push_fire && !pop_fire) |=> (r_count == $past(r_count) + 1'b1)))
    `ASSERT_PROP(a_rd_advance, i_clk, i_rst_n, (pop_fire |=> (r_rd_ptr != $past(r_rd_ptr))))

endmodule

/* sv/sbbs_front.sv */
`timescale 1ns / 1ps

module sbbs_front #(
    parameter int STEP_COUNT = 16,
    parameter int TIME_BITS  = 16,
    parameter int INSTR_W    = 1
) (
    input  logic [sbbs_pkg::KIND_W-1:0]    i_kind,
    input  logic [sbbs_pkg::STEP_IN_W-1:0] i_step_index,
    input  logic [sbbs_pkg::TIME_IN_W-1:0] i_time_now,
    input  logic                           i_is_playing,
    input  logic                           i_button_level,
    input  logic [sbbs_pkg::WORD_W-1:0]    i_pattern_word,
    output logic [INSTR_W-1:0]             o_instr
);

    import sbbs_pkg::*;

    localparam int IDX_W  = $clog2(STEP_COUNT);
    localparam int IDXX_W = (IDX_W > STEP_IN_W) ? IDX_W : STEP_IN_W;
    localparam int TW     = (TIME_BITS > TIME_IN_W) ? TIME_BITS : TIME_IN_W;
    localparam int PW     = (STEP_COUNT > WORD_W) ? STEP_COUNT : WORD_W;

    logic [IDXX_W-1:0]     step_ext;
    logic [IDX_W-1:0]      idx, pos;
    logic [TW-1:0]         time_ext;
    logic [PW-1:0]         word_ext;
    logic                  in_range;
    t_op                   op;

    assign step_ext = IDXX_W'(i_step_index);
    assign idx      = step_ext[IDX_W-1:0];
    // Step 0 sits at the most significant pattern bit.
    assign pos      = IDX_W'(STEP_COUNT - 1) - idx;
    assign in_range = int'(i_step_index) < STEP_COUNT;
    assign time_ext = TW'(i_time_now);
    assign word_ext = PW'(i_pattern_word);

    always_comb begin
        case (i_kind)
            KIND_SCAN:  op = in_range ? OP_SCAN : OP_NOP;
            KIND_BLINK: op = OP_BLINK;
            KIND_LOAD:  op = OP_LOAD;
            default:    op = OP_NOP;
        endcase
    end

    assign o_instr = {op, idx, pos, time_ext[TIME_BITS-1:0], i_is_playing, i_button_level,
                      word_ext[STEP_COUNT-1:0]};

endmodule

/* sv/sbbs_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbbs_back #(
    parameter int STEP_COUNT = 16,
    parameter int TIME_BITS  = 16,
    parameter int INSTR_W    = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sbbs_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_iq_empty,
    input  logic [INSTR_W-1:0]         i_iq_data,
    output logic                       o_iq_pop,
    input  logic                       i_rq_full,
    output logic                       o_rq_push,
    output sbbs_pkg::t_result          o_rq_data
);

    import sbbs_pkg::*;

    localparam int IDX_W = $clog2(STEP_COUNT);
    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int PW    = (STEP_COUNT > WORD_W) ? STEP_COUNT : WORD_W;

    // Fields of the queue head.
    logic [1:0]            h_op;
    logic [IDX_W-1:0]      h_idx, h_pos;
    logic [TIME_BITS-1:0]  h_time;
    logic                  h_play, h_level;
    logic [STEP_COUNT-1:0] h_word;

    // Execute register.
    logic                  r_a_vld;
    t_op                   r_a_op;
    logic [IDX_W-1:0]      r_a_idx, r_a_pos;
    logic [TIME_BITS-1:0]  r_a_time;
    logic                  r_a_play, r_a_level;
    logic [STEP_COUNT-1:0] r_a_word;
    logic [TIME_BITS-1:0]  r_a_stamp, r_a_fwd_time;
    logic                  r_a_fwd, r_a_stamp_vld;

    // Block state.
    logic [CFG_W-1:0]      r_debounce;
    logic [STEP_COUNT-1:0] r_pattern, n_pattern;
    logic [STEP_COUNT-1:0] r_pressed, n_pressed;
    logic [1:0]            r_phase, n_phase;
    logic [TIME_BITS-1:0]  r_stamp_mem [STEP_COUNT];
    logic [STEP_COUNT-1:0] r_stamp_vld;

    logic                  load_a, exec_fire, stamp_we, n_stamp;
    logic                  active, was_pressed, settled, led, tog;
    logic [TIME_BITS-1:0]  last_time, elapsed;
    logic [PW-1:0]         pat_ext;

    assign {h_op, h_idx, h_pos, h_time, h_play, h_level, h_word} = i_iq_data;

    assign exec_fire = r_a_vld && !i_rq_full;
    assign load_a    = !i_iq_empty && (!r_a_vld || exec_fire);
    assign o_iq_pop  = load_a;
    assign stamp_we  = exec_fire && n_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (load_a) begin
            r_a_vld <= 1'b1;
        end else if (exec_fire) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_op       <= t_op'(h_op);
            r_a_idx      <= h_idx;
            r_a_pos      <= h_pos;
            r_a_time     <= h_time;
            r_a_play     <= h_play;
            r_a_level    <= h_level;
            r_a_word     <= h_word;
            // A stamp written this cycle to the same step is passed on directly.
            r_a_fwd      <= stamp_we && (r_a_idx == h_idx);
            r_a_fwd_time <= r_a_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            r_stamp_mem[r_a_idx] <= r_a_time;
        end
        if (load_a) begin
            r_a_stamp <= r_stamp_mem[h_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp_vld   <= '0;
            r_a_stamp_vld <= 1'b0;
        end else begin
            if (stamp_we) begin
                r_stamp_vld[r_a_idx] <= 1'b1;
            end
            if (load_a) begin
                r_a_stamp_vld <= r_stamp_vld[h_idx];
            end
        end
    end

    assign last_time   = r_a_fwd ? r_a_fwd_time : (r_a_stamp_vld ? r_a_stamp : '0);
    assign elapsed     = r_a_time - last_time;
    assign settled     = CMP_W'(elapsed) > CMP_W'(r_debounce);
    assign active      = r_pattern[r_a_pos];
    assign was_pressed = r_pressed[r_a_pos];

    always_comb begin
        n_pattern = r_pattern;
        n_pressed = r_pressed;
        n_phase   = r_phase;
        n_stamp   = 1'b0;
        led       = 1'b0;
        tog       = 1'b0;
        case (r_a_op)
            OP_SCAN: begin
                if (active && r_a_play) begin
                    led = 1'b1;
                end else if (active) begin
                    led = !r_phase[1];
                end else if (r_a_play) begin
                    led = (r_phase == 2'd0);
                end
                if (settled && (r_a_level != was_pressed)) begin
                    n_stamp = 1'b1;
                    n_pressed[r_a_pos] = r_a_level;
                    if (r_a_level) begin
                        n_pattern[r_a_pos] = !active;
                        tog = 1'b1;
                    end
                end
            end
            OP_BLINK: n_phase   = r_phase + 2'd1;
            OP_LOAD:  n_pattern = r_a_word;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern  <= '0;
            r_pressed  <= '0;
            r_phase    <= '0;
            r_debounce <= DEBOUNCE_RESET;
        end else begin
            if (exec_fire) begin
                r_pattern <= n_pattern;
                r_pressed <= n_pressed;
                r_phase   <= n_phase;
            end
            if (i_cfg_we) begin
                r_debounce <= i_cfg_wdata;
            end
        end
    end

    assign pat_ext           = PW'(n_pattern);
    assign o_rq_push         = exec_fire;
    assign o_rq_data.led_on  = led;
    assign o_rq_data.pattern = pat_ext[WORD_W-1:0];
    assign o_rq_data.toggled = tog;

    `ASSERT_PROP(a_toggle_changes, i_clk, i_rst_n, ((exec_fire && tog) |-> (n_pattern != r_pattern)))
    `ASSERT_PROP(a_stamp_on_scan, i_clk, i_rst_n, (stamp_we |-> (r_a_op == OP_SCAN)))
    `ASSERT_PROP(a_blink_step, i_clk, i_rst_n, ((exec_fire && (r_a_op == OP_BLINK)) |=> (r_phase == $past(r_phase) + 2'd1)))

endmodule

/* sv/step_button_bank_scanner_unit.sv */
`timescale 1ns / 1ps
// Step button bank scanner: debounces a bank of step buttons and drives their LEDs.
// Items enter through push/full: an item is taken at a clock edge with push high
// and full low. Kind 0 scans one step, kind 1 advances the blink phase, kind 2
// loads a new step pattern. Every item yields exactly one result.
// Results leave through empty/pop: the oldest result sits on the o_ ports while
// empty is low and is taken at a clock edge with pop high.
// The debounce register is written by i_cfg_we/i_cfg_wdata; the user must write
// it only while the block is idle, which the block does not enforce. Items pass
// through the item queue, the execute register and the result queue. Throughput:
// one item per cycle while the result queue has room; the back end does one
// read-modify-write of the step state per cycle, reading the step's stamp from
// the stamp memory on entry to execute (bypassed if the last item wrote that step).
// When pop stays low the result queue fills, the back end stalls, the item queue
// fills behind it and full rises; nothing is lost. Reset (i_rst_n low at a clock
// edge) empties both queues, clears pattern, pressed bits, time stamps and blink
// phase, and sets the debounce time to 50 ticks.

module step_button_bank_scanner_unit #(
    parameter int STEP_COUNT = sbbs_pkg::SBBS_STEP_COUNT,
    parameter int TIME_BITS  = sbbs_pkg::SBBS_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sbbs_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           push,
    output logic                           full,
    input  logic [sbbs_pkg::KIND_W-1:0]    i_kind,
    input  logic [sbbs_pkg::STEP_IN_W-1:0] i_step_index,
    input  logic [sbbs_pkg::TIME_IN_W-1:0] i_time_now,
    input  logic                           i_is_playing,
    input  logic                           i_button_level,
    input  logic [sbbs_pkg::WORD_W-1:0]    i_pattern_word,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_led_on,
    output logic [sbbs_pkg::WORD_W-1:0]    o_pattern,
    output logic                           o_toggled
);

    import sbbs_pkg::*;

    localparam int IDX_W   = $clog2(STEP_COUNT);
    localparam int INSTR_W = 2 + 2 * IDX_W + TIME_BITS + 2 + STEP_COUNT;
    localparam int RES_W   = $bits(t_result);

    logic [INSTR_W-1:0] fe_instr, iq_data;
    logic               iq_empty, iq_pop;
    logic               rq_full, rq_push;
    t_result            rq_in, rq_out;

    sbbs_front #(
        .STEP_COUNT (STEP_COUNT),
        .TIME_BITS  (TIME_BITS),
        .INSTR_W    (INSTR_W)
    ) u_front (
        .i_kind         (i_kind),
        .i_step_index   (i_step_index),
        .i_time_now     (i_time_now),
        .i_is_playing   (i_is_playing),
        .i_button_level (i_button_level),
        .i_pattern_word (i_pattern_word),
        .o_instr        (fe_instr)
    );

    sbbs_fifo #(
        .WIDTH (INSTR_W),
        .DEPTH (IQ_DEPTH)
    ) u_iq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fe_instr),
        .o_full  (full),
        .i_pop   (iq_pop),
        .o_empty (iq_empty),
        .o_data  (iq_data)
    );

    sbbs_back #(
        .STEP_COUNT (STEP_COUNT),
        .TIME_BITS  (TIME_BITS),
        .INSTR_W    (INSTR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_iq_empty  (iq_empty),
        .i_iq_data   (iq_data),
        .o_iq_pop    (iq_pop),
        .i_rq_full   (rq_full),
        .o_rq_push   (rq_push),
        .o_rq_data   (rq_in)
    );

    sbbs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RQ_DEPTH)
    ) u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (rq_out)
    );

    assign o_led_on  = rq_out.led_on;
    assign o_pattern = rq_out.pattern;
    assign o_toggled = rq_out.toggled;

endmodule

/* test/step_button_bank_scanner_unit_checker.sv */
`timescale 1ns / 1ps

module step_button_bank_scanner_unit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sbbs_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [sbbs_pkg::KIND_W-1:0]    i_kind,
    input  logic [sbbs_pkg::STEP_IN_W-1:0] i_step_index,
    input  logic [sbbs_pkg::TIME_IN_W-1:0] i_time_now,
    input  logic                           i_is_playing,
    input  logic                           i_button_level,
    input  logic [sbbs_pkg::WORD_W-1:0]    i_pattern_word,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic                           i_led_on,
    input  logic [sbbs_pkg::WORD_W-1:0]    i_pattern,
    input  logic                           i_toggled,
    output int                             o_fail_count,
    output int                             o_results_due
);
    import sbbs_pkg::*;

    localparam int STEPS = SBBS_STEP_COUNT;

    logic [CFG_W-1:0]     debounce_q;
    logic [WORD_W-1:0]    pattern_q;
    logic [WORD_W-1:0]    pressed_q;
    logic [TIME_IN_W-1:0] stamp_q [STEPS];
    logic [1:0]           blink_q;

    t_result scan_results_due [$];
    int      mismatches = 0;

    // Applies one item to the mirrored scanner state and returns its result.
    function automatic t_result scanner_outcome(
        input logic [KIND_W-1:0]    kind,
        input logic [STEP_IN_W-1:0] idx,
        input logic [TIME_IN_W-1:0] now,
        input logic                 playing,
        input logic                 level,
        input logic [WORD_W-1:0]    word
    );
        t_result              res;
        logic [WORD_W-1:0]    step_bit;
        logic                 active;
        logic [TIME_IN_W-1:0] elapsed;
        res = '0;
        if (kind == KIND_SCAN && idx < STEPS) begin
            // Step 0 lives in the top bit of the pattern.
            step_bit = {{(WORD_W-1){1'b0}}, 1'b1} << (STEPS - 1 - idx);
            active = |(pattern_q & step_bit);
            if (active && playing) begin
                res.led_on = 1'b1;
            end else if (active) begin
                res.led_on = (blink_q < 2'd2);
            end else if (playing) begin
                res.led_on = (blink_q < 2'd1);
            end
            elapsed = now - stamp_q[idx];
            if (elapsed > debounce_q && level != |(pressed_q & step_bit)) begin
                if (level) begin
                    pattern_q   = pattern_q ^ step_bit;
                    pressed_q   = pressed_q | step_bit;
                    res.toggled = 1'b1;
                end else begin
                    pressed_q = pressed_q & ~step_bit;
                end
                stamp_q[idx] = now;
            end
        end else if (kind == KIND_BLINK) begin
            blink_q = blink_q + 2'd1;
        end else if (kind == KIND_LOAD) begin
            pattern_q = word;
        end
        res.pattern = pattern_q;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            debounce_q = DEBOUNCE_RESET;
            pattern_q  = '0;
            pressed_q  = '0;
            blink_q    = '0;
            for (int i = 0; i < STEPS; i++) begin
                stamp_q[i] = '0;
            end
            scan_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                debounce_q = i_cfg_wdata;
            end
            if (i_pop && !i_empty) begin
                if (scan_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: led_on %0b pattern %04h toggled %0b",
                                 i_led_on, i_pattern, i_toggled);
                    end
                end else begin
                    want = scan_results_due.pop_front();
                    if (want.led_on !== i_led_on || want.pattern !== i_pattern ||
                        want.toggled !== i_toggled) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected led_on %0b pattern %04h toggled %0b, %s",
                                     want.led_on, want.pattern, want.toggled,
                                     $sformatf("got led_on %0b pattern %04h toggled %0b",
                                               i_led_on, i_pattern, i_toggled));
                        end
                    end
                end
            end
            if (i_push && !i_full) begin
                scan_results_due.push_back(scanner_outcome(i_kind, i_step_index, i_time_now,
                                                           i_is_playing, i_button_level,
                                                           i_pattern_word));
            end
        end
        o_results_due <= scan_results_due.size();
        o_fail_count  <= mismatches;
    end

endmodule

/* test/step_button_bank_scanner_unit_tb.sv */
`timescale 1ns / 1ps

module step_button_bank_scanner_unit_tb;
    import sbbs_pkg::*;

    // The kind code that the block treats as a no-op.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int IDLE_PCT     = 19;
    localparam int HOLD_CYCLES  = 64;
    localparam int STEADY_FROM  = 600;
    localparam int STEADY_TO    = 900;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 push;
    logic                 full;
    logic [KIND_W-1:0]    i_kind;
    logic [STEP_IN_W-1:0] i_step_index;
    logic [TIME_IN_W-1:0] i_time_now;
    logic                 i_is_playing;
    logic                 i_button_level;
    logic [WORD_W-1:0]    i_pattern_word;
    logic                 empty;
    logic                 pop;
    logic                 o_led_on;
    logic [WORD_W-1:0]    o_pattern;
    logic                 o_toggled;

    int fail_count;
    int results_due;
    int items_sent    = 0;
    int results_taken = 0;
    int stall_cycles  = 0;

    logic [CFG_W-1:0]     debounce_now;
    logic [TIME_IN_W-1:0] time_cursor;
    logic [STEP_IN_W-1:0] last_step;
    logic                 btn_level [SBBS_STEP_COUNT];

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    step_button_bank_scanner_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_step_index   (i_step_index),
        .i_time_now     (i_time_now),
        .i_is_playing   (i_is_playing),
        .i_button_level (i_button_level),
        .i_pattern_word (i_pattern_word),
        .empty          (empty),
        .pop            (pop),
        .o_led_on       (o_led_on),
        .o_pattern      (o_pattern),
        .o_toggled      (o_toggled)
    );

    step_button_bank_scanner_unit_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_push         (push),
        .i_full         (full),
        .i_kind         (i_kind),
        .i_step_index   (i_step_index),
        .i_time_now     (i_time_now),
        .i_is_playing   (i_is_playing),
        .i_button_level (i_button_level),
        .i_pattern_word (i_pattern_word),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_led_on       (o_led_on),
        .i_pattern      (o_pattern),
        .i_toggled      (o_toggled),
        .o_fail_count   (fail_count),
        .o_results_due  (results_due)
    );

    // Result side: random pops, a steady window, and two long hold-offs that
    // back the block up until it refuses items.
    initial begin
        int hold_left;
        int next_hold;
        hold_left = 0;
        next_hold = 300;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                results_taken++;
            end
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (results_taken >= next_hold) begin
                pop <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                next_hold = (next_hold == 300) ? 1200 : 32'h7fff_ffff;
            end else if (results_taken >= STEADY_FROM && results_taken < STEADY_TO) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(
        input logic [KIND_W-1:0]    kind,
        input logic [STEP_IN_W-1:0] idx,
        input logic [TIME_IN_W-1:0] now,
        input logic                 playing,
        input logic                 level,
        input logic [WORD_W-1:0]    word
    );
        while (!(items_sent >= STEADY_FROM && items_sent < STEADY_TO) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_kind         <= kind;
        i_step_index   <= idx;
        i_time_now     <= now;
        i_is_playing   <= playing;
        i_button_level <= level;
        i_pattern_word <= word;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_debounce(input logic [CFG_W-1:0] ticks);
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= ticks;
        debounce_now = ticks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly press/release sequences on a moving time base, with the other
    // kinds and some scans at random times mixed in.
    task automatic random_phase(input int n_items);
        int                   gap_max;
        int                   pick;
        logic [STEP_IN_W-1:0] idx;
        gap_max = (debounce_now > 16'd2000) ? 4000 : debounce_now / 4 + 4;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                idx = ($urandom_range(0, 99) < 30) ? last_step
                                                   : STEP_IN_W'($urandom_range(0, 15));
                time_cursor = time_cursor + TIME_IN_W'($urandom_range(0, gap_max));
                if ($urandom_range(0, 99) < 60) begin
                    btn_level[idx] = !btn_level[idx];
                end
                last_step = idx;
                send_item(KIND_SCAN, idx, time_cursor, ($urandom_range(0, 3) == 0),
                          btn_level[idx], WORD_W'($urandom));
            end else if (pick < 82) begin
                send_item(KIND_BLINK, STEP_IN_W'($urandom_range(0, 15)), TIME_IN_W'($urandom),
                          ($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1),
                          WORD_W'($urandom));
            end else if (pick < 88) begin
                send_item(KIND_LOAD, STEP_IN_W'($urandom_range(0, 15)), TIME_IN_W'($urandom),
                          ($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1),
                          WORD_W'($urandom));
            end else if (pick < 91) begin
                send_item(KIND_SPARE, STEP_IN_W'($urandom_range(0, 15)), TIME_IN_W'($urandom),
                          ($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1),
                          WORD_W'($urandom));
            end else begin
                send_item(KIND_SCAN, STEP_IN_W'($urandom_range(0, 15)), TIME_IN_W'($urandom),
                          ($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1),
                          WORD_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        push           <= 1'b0;
        i_kind         <= KIND_SCAN;
        i_step_index   <= '0;
        i_time_now     <= '0;
        i_is_playing   <= 1'b0;
        i_button_level <= 1'b0;
        i_pattern_word <= '0;
        debounce_now = DEBOUNCE_RESET;
        time_cursor  = '0;
        last_step    = '0;
        for (int i = 0; i < SBBS_STEP_COUNT; i++) begin
            btn_level[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Exactly the debounce time is not enough; one tick more is.
        send_item(KIND_SCAN, 4'd0, 16'd50, 1'b0, 1'b1, 16'hFFFF);
        send_item(KIND_SCAN, 4'd0, 16'd51, 1'b0, 1'b1, 16'h0000);
        send_item(KIND_SCAN, 4'd0, 16'd60, 1'b1, 1'b0, 16'h0000);
        send_item(KIND_SCAN, 4'd0, 16'd200, 1'b0, 1'b0, 16'h0000);
        // Walk the blink phase through all four values and back to zero.
        send_item(KIND_BLINK, 4'd15, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
        send_item(KIND_SCAN, 4'd0, 16'd210, 1'b0, 1'b0, 16'h0000);
        send_item(KIND_SCAN, 4'd5, 16'd300, 1'b1, 1'b0, 16'h0000);
        send_item(KIND_BLINK, 4'd0, 16'h0000, 1'b0, 1'b0, 16'h0000);
        send_item(KIND_SCAN, 4'd0, 16'd310, 1'b0, 1'b0, 16'h0000);
        send_item(KIND_SCAN, 4'd5, 16'd320, 1'b1, 1'b0, 16'h0000);
        send_item(KIND_SCAN, 4'd0, 16'd330, 1'b1, 1'b0, 16'h0000);
        send_item(KIND_BLINK, 4'd3, 16'h1111, 1'b0, 1'b1, 16'h0000);
        send_item(KIND_SCAN, 4'd0, 16'd340, 1'b0, 1'b0, 16'h0000);
        send_item(KIND_BLINK, 4'd7, 16'h2222, 1'b1, 1'b0, 16'h0000);
        send_item(KIND_SCAN, 4'd5, 16'd350, 1'b1, 1'b0, 16'h0000);
        send_item(KIND_LOAD, 4'd0, 16'h0000, 1'b0, 1'b0, 16'hFFFF);
        send_item(KIND_LOAD, 4'd15, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_item(KIND_LOAD, 4'd8, 16'h8000, 1'b0, 1'b1, 16'hA5C3);
        send_item(KIND_SPARE, 4'd9, 16'h1234, 1'b1, 1'b1, 16'h5A5A);
        // Last step, with the elapsed time wrapping past zero.
        send_item(KIND_SCAN, 4'd15, 16'hFFFF, 1'b1, 1'b1, 16'h0000);
        send_item(KIND_SCAN, 4'd15, 16'h0040, 1'b0, 1'b0, 16'h0000);
        send_item(KIND_SCAN, 4'd15, 16'h0050, 1'b0, 1'b1, 16'h0000);
        send_item(KIND_SCAN, 4'd15, 16'h0050, 1'b0, 1'b1, 16'h0000);
        time_cursor = 16'h0100;

        random_phase(700);
        wait_drained();
        write_debounce(16'd0);
        random_phase(400);
        wait_drained();
        write_debounce(16'hFFFF);
        random_phase(150);
        wait_drained();
        write_debounce(CFG_W'($urandom_range(2, 300)));
        random_phase(300);
        wait_drained();
        write_debounce(16'd1);
        random_phase(330);
        wait_drained();

        if (fail_count == 0 && results_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
